// ===== hw/rtl/bmpc_pkg.sv =====
package bmpc_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_ADDR_W      = 8;
	localparam int PAL_COUNT_W     = 10;
	localparam int CFG_INDEX_W     = 4;
	localparam int CFG_DATA_W      = 13;
	localparam int COORD_W         = 12;
	localparam int PIXEL_W         = 32;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SOURCE_PALETTED = 4'd0,
		CFG_OUTPUT_FORMAT   = 4'd1,
		CFG_IMAGE_WIDTH     = 4'd2,
		CFG_IMAGE_HEIGHT    = 4'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		FMT_RGB565 = 2'd0,
		FMT_RGB555 = 2'd1,
		FMT_RGB24  = 2'd2,
		FMT_RGB32  = 2'd3
	} out_format_t;

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_IMAGE   = 1'b1;

	// Colour conversion of one pixel from its three source bytes.
	function automatic logic [PIXEL_W-1:0] convert_pixel(
		input out_format_t fmt,
		input logic [7:0]  b0,
		input logic [7:0]  b1,
		input logic [7:0]  b2
	);
		logic [PIXEL_W-1:0] res;
		begin
			case (fmt)
				FMT_RGB565: res = {16'h0000, b2[7:3], b1[7:2], b0[7:3]};
				FMT_RGB555: res = {17'h00000, b2[7:3], b1[7:3], b0[7:3]};
				FMT_RGB24: res = {8'h00, b2, b1, b0};
				FMT_RGB32: res = {8'h00, b2, b1, b0};
				default: res = {8'h00, b2, b1, b0};
			endcase
			return res;
		end
	endfunction

endpackage

// ===== hw/rtl/bmpc_ram.sv =====
module bmpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bmp_pixel_stream_converter.sv =====
// BMP body to pixel stream converter.
// Input stream: one byte of the BMP body per word, in file order. tuser is 0 for
// a palette byte and 1 for an image byte. Palette bytes fill a 256-entry palette,
// four bytes per entry of which the first three are kept. Image bytes arrive as
// bottom-up rows padded to four bytes; padding is dropped.
// Output stream: one word per pixel with the converted value, the destination
// column and the top-down row; tlast marks the last pixel of the image.
// Configuration: a separate write channel (cfg_valid, cfg_index, cfg_data),
// always ready, to be written only while the stream is idle.
// Throughput is one input word per cycle while the receiver keeps up. The byte that
// completes a pixel starts the palette memory read into the first stage; conversion
// follows into the output register as soon as that register is free or draining.
// A receiver stall fills the output register, then the first stage, and only
// then drops s_axis_tready; nothing is lost. Reset clears all counters, the
// configuration and both pipeline stages; palette contents are left as they were
// and must be loaded before paletted pixels refer to them.
module bmp_pixel_stream_converter
	import bmpc_pkg::*;
#(
	parameter int MAX_DIM = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
	input  logic                   s_axis_tuser,   // [0] kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [55:0]            m_axis_tdata,   // [31:0] pixel_value, [43:32] column,
	                                               // [55:44] row
	output logic                   m_axis_tlast,   // end_of_image
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = CNT_W + 1;
	localparam int XW    = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
	localparam int RW    = (DIM_W > COORD_W) ? DIM_W : COORD_W;

	// Configuration
	logic              src_pal_q;
	out_format_t       fmt_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [XW-1:0]     cfg_ext;
	logic [DIM_W-1:0]  cfg_dim;

	// Parser state
	logic [PAL_COUNT_W-1:0] pal_cnt_q;
	logic [1:0]             bip_q;
	logic [15:0]            held_q;
	logic [CNT_W-1:0]       col_q;
	logic [1:0]             pad_q;
	logic [CNT_W-1:0]       frow_q;

	// First stage
	logic               s1_valid_q;
	logic               s1_pal_s1;
	logic [23:0]        s1_bytes_s1;
	logic [COORD_W-1:0] s1_col_s1;
	logic [COORD_W-1:0] s1_row_s1;
	logic               s1_eoi_s1;

	// Output register
	logic               m_valid_q;
	logic [PIXEL_W-1:0] pix_q;
	logic [COORD_W-1:0] col_out_q;
	logic [COORD_W-1:0] row_out_q;
	logic               eoi_q;

	logic               accept;
	logic               is_img;
	logic               emit;
	logic               advance;
	logic               last_col;
	logic               last_row;
	logic [DIM_W-1:0]   col_next;
	logic [DIM_W-1:0]   row_next;
	logic [RW-1:0]      row_dest;
	logic [1:0]         pad_new;
	logic [7:0]         pal_rd [3];
	logic [7:0]         b0;
	logic [7:0]         b1;
	logic [7:0]         b2;

	assign cfg_ready = 1'b1;

	// Dimensions are clamped once at the configuration write.
	assign cfg_ext = XW'(cfg_data);
	always_comb begin
		if (cfg_ext == '0) begin
			cfg_dim = DIM_W'(1);
		end else if (cfg_ext > XW'(MAX_DIM)) begin
			cfg_dim = DIM_W'(MAX_DIM);
		end else begin
			cfg_dim = DIM_W'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_pal_q <= 1'b0;
			fmt_q     <= FMT_RGB565;
			width_q   <= DIM_W'(1);
			height_q  <= DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SOURCE_PALETTED: src_pal_q <= cfg_data[0];
				CFG_OUTPUT_FORMAT: fmt_q <= out_format_t'(cfg_data[1:0]);
				CFG_IMAGE_WIDTH: width_q <= cfg_dim;
				CFG_IMAGE_HEIGHT: height_q <= cfg_dim;
				default: ;
			endcase
		end
	end

	// Handshake: the first stage moves on when the output register is free.
	assign advance       = s1_valid_q && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_img        = (s_axis_tuser == KIND_IMAGE);

	assign emit = accept && is_img && (pad_q == 2'd0) && (src_pal_q || (bip_q >= 2'd2));

	assign col_next = DIM_W'(col_q) + DIM_W'(1);
	assign row_next = DIM_W'(frow_q) + DIM_W'(1);
	assign last_col = (col_next >= width_q);
	assign last_row = (row_next >= height_q);
	assign row_dest = RW'(height_q) - RW'(1) - RW'(frow_q);

	// Row padding: a paletted row of w bytes needs (-w) mod 4, a 24-bit row w mod 4.
	assign pad_new = src_pal_q ? (2'd0 - width_q[1:0]) : width_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_cnt_q <= '0;
			bip_q     <= 2'd0;
			held_q    <= 16'h0000;
			col_q     <= '0;
			pad_q     <= 2'd0;
			frow_q    <= '0;
		end else if (accept) begin
			if (!is_img) begin
				pal_cnt_q <= pal_cnt_q + PAL_COUNT_W'(1);
			end else if (pad_q != 2'd0) begin
				pad_q <= pad_q - 2'd1;
			end else if (!src_pal_q && bip_q == 2'd0) begin
				held_q[7:0] <= s_axis_tdata;
				bip_q       <= 2'd1;
			end else if (!src_pal_q && bip_q == 2'd1) begin
				held_q[15:8] <= s_axis_tdata;
				bip_q        <= 2'd2;
			end else begin
				if (!src_pal_q) begin
					bip_q <= 2'd0;
				end
				if (last_col) begin
					col_q  <= '0;
					pad_q  <= pad_new;
					frow_q <= last_row ? '0 : CNT_W'(row_next);
				end else begin
					col_q <= CNT_W'(col_next);
				end
			end
		end
	end

	// Palette: one byte-wide memory per colour byte, so a palette word writes
	// only its own byte of the entry.
	for (genvar lane = 0; lane < 3; lane++) begin : g_pal
		bmpc_ram #(
			.WIDTH(8),
			.DEPTH(PALETTE_ENTRIES)
		) u_pal (
			.clk    (clk),
			.wr_en  (accept && !is_img && (pal_cnt_q[1:0] == 2'(lane))),
			.wr_addr(pal_cnt_q[PAL_COUNT_W-1:2]),
			.wr_data(s_axis_tdata),
			.rd_en  (emit),
			.rd_addr(s_axis_tdata[PAL_ADDR_W-1:0]),
			.rd_data(pal_rd[lane])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (emit) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			s1_pal_s1   <= src_pal_q;
			s1_bytes_s1 <= {s_axis_tdata, held_q};
			s1_col_s1   <= COORD_W'(col_q);
			s1_row_s1   <= row_dest[COORD_W-1:0];
			s1_eoi_s1   <= last_col && last_row;
		end
	end

	assign b0 = s1_pal_s1 ? pal_rd[0] : s1_bytes_s1[7:0];
	assign b1 = s1_pal_s1 ? pal_rd[1] : s1_bytes_s1[15:8];
	assign b2 = s1_pal_s1 ? pal_rd[2] : s1_bytes_s1[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q     <= convert_pixel(fmt_q, b0, b1, b2);
			col_out_q <= s1_col_s1;
			row_out_q <= s1_row_s1;
			eoi_q     <= s1_eoi_s1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {row_out_q, col_out_q, pix_q};
	assign m_axis_tlast  = eoi_q;

endmodule
